// ----- hw/rtl/rcfdd_pkg.sv -----
`default_nettype none

package rcfdd_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MIX_RCP,
    ST_MIX_FIX,
    ST_SC_MUL,
    ST_SC_RCP,
    ST_SC_FIX,
    ST_EMIT
  } rcfdd_state_t;

  // Result status codes
  localparam logic [1:0] STAT_APPLIED  = 2'd0;
  localparam logic [1:0] STAT_CHK_ERR  = 2'd1;
  localparam logic [1:0] STAT_MISSED   = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT  = 2'd3;

  // Motor direction codes
  localparam logic [1:0] DIR_STOP    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  // Input kind codes
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MAX    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 1'd1;

  // Switch byte bits
  localparam int unsigned SW_FWD_BIT = 0;
  localparam int unsigned SW_REV_BIT = 1;

  // Shared multiplier widths
  localparam int unsigned MUL_A_W  = 24;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  // Reciprocals: x/127 for x < 2^15 as (x*258)>>15, x/255 for x < 2^24 as
  // (x*65793)>>24; both estimates are at most one low and get one correction.
  localparam int unsigned RCP127_SH = 15;
  localparam int unsigned RCP255_SH = 24;
  localparam logic [MUL_B_W-1:0] RCP127 = 17'd258;
  localparam logic [MUL_B_W-1:0] RCP255 = 17'd65793;

  localparam logic [7:0]  MIX_OFFSET  = 8'd127;
  localparam logic [7:0]  BYTE_NEG_MAX = 8'h80;
  localparam logic [7:0]  BYTE_NEG_CLAMP = 8'h81;
  localparam logic [15:0] MISS_SAT    = 16'hffff;

endpackage

`default_nettype wire

// ----- hw/rtl/rc_frame_differential_drive.sv -----
`default_nettype none

// Differential-drive steering mixer for a remote-control receiver.
// Input channel (in_valid/in_ready): one word per received frame or per poll.
//   A frame carries steering, throttle, switch and spare bytes plus its
//   checksum byte; a poll (in_kind high) reports a missed or bad reception.
// Result channel (out_valid/out_ready): exactly one word per input word, with
//   a status code and the held direction and motor duties after that word.
// Configuration port: cfg_we with cfg_index 0 writes pwm_max, index 1 writes
//   miss_limit; write only while the block is idle.
// Sequencing: a poll or a frame with a bad checksum goes from evaluation
//   straight to the final step; a good frame first passes through the one
//   shared multiplier, which forms the mix product, the divide-by-127
//   reciprocal product and, per motor, the pwm_max product and the
//   divide-by-255 reciprocal product, in turn. One word is in flight at
//   a time; in_ready is high only when the sequencer is idle, so the next
//   word waits until the result of the last has left the sequencer.
// Reset: synchronous on rst_n low; direction stop, duties and miss count zero,
//   pwm_max 255, miss_limit 100, no result pending.
// Stall: a finished result sits in the output register until taken; the next
//   word is accepted meanwhile, and its result waits in the final step until
//   the output register frees.
module rc_frame_differential_drive (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_kind,
  input  wire logic signed [7:0]                 in_steering,
  input  wire logic signed [7:0]                 in_throttle,
  input  wire logic [7:0]                        in_switches,
  input  wire logic [7:0]                        in_spare_channel,
  input  wire logic [7:0]                        in_frame_sum,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic [1:0]                             out_direction,
  output logic [15:0]                            out_duty_one,
  output logic [15:0]                            out_duty_two,
  input  wire logic                              cfg_we,
  input  wire logic [rcfdd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                       cfg_wdata
);
  import rcfdd_pkg::*;

  // Sequencer and control state
  rcfdd_state_t state_r, state_nxt;
  logic         sel_two_r, sel_two_nxt;     // scaling motor two when high
  logic         out_valid_r, out_valid_nxt;

  // Configuration
  logic [15:0] pwm_max_r, miss_limit_r;

  // Held drive state
  logic [1:0]  dir_r, dir_nxt;
  logic [15:0] duty_one_r, duty_one_nxt;
  logic [15:0] duty_two_r, duty_two_nxt;
  logic [15:0] miss_r, miss_nxt;

  // Latched input word
  logic             kind_r;
  logic [7:0]       steer_r, thr_r, sw_r, spare_r, fsum_r;

  // Working registers
  logic [1:0]         status_r, status_nxt;
  logic [7:0]         d_one_r, d_one_nxt;
  logic [7:0]         d_two_r, d_two_nxt;
  logic [15:0]        scaled_one_r, scaled_one_nxt;
  logic [MUL_A_W-1:0] x_r;
  logic [PROD_W-1:0]  prod_r;

  // Output register
  logic [1:0]  out_status_r, out_dir_r;
  logic [15:0] out_duty_one_r, out_duty_two_r;

  // Shared multiplier operands
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // Frame decode
  logic [7:0] chk_sum;
  logic       chk_ok;
  logic [7:0] s_cl, t_cl, s_off, t_base;
  logic       s_neg;
  logic [6:0] mix_a;

  // Divide-by-127 correction
  logic [7:0]  q127;
  logic [15:0] rem127;
  logic [7:0]  q127_fix;

  // Divide-by-255 correction
  logic [15:0] q255;
  logic [MUL_A_W:0] rem255;
  logic [15:0] q255_fix;
  logic [7:0]  d_sel;

  logic in_acc;
  logic out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_direction = out_dir_r;
  assign out_duty_one  = out_duty_one_r;
  assign out_duty_two  = out_duty_two_r;

  // Checksum: inverted low byte of the sum of the four channel bytes
  assign chk_sum = steer_r + thr_r + sw_r + spare_r;
  assign chk_ok  = (~chk_sum == fsum_r);

  // Clamp -128 to -127; offsets wrap modulo 256 into the 0..254 range
  assign s_cl   = (steer_r == BYTE_NEG_MAX) ? BYTE_NEG_CLAMP : steer_r;
  assign t_cl   = (thr_r == BYTE_NEG_MAX) ? BYTE_NEG_CLAMP : thr_r;
  assign s_neg  = s_cl[7];
  assign s_off  = s_cl + MIX_OFFSET;
  assign t_base = t_cl + MIX_OFFSET;
  assign mix_a  = s_neg ? s_off[6:0] : s_cl[6:0];

  // Quotient estimate is at most one low: one compare and bump fixes it
  assign q127     = prod_r[RCP127_SH+7:RCP127_SH];
  assign rem127   = {1'b0, x_r[14:0]} - ({1'b0, q127, 7'b0} - {8'b0, q127});
  assign q127_fix = q127 + {7'b0, (rem127 >= 16'd127)};

  assign q255     = prod_r[RCP255_SH+15:RCP255_SH];
  assign rem255   = {1'b0, x_r} - ({1'b0, q255, 8'b0} - {9'b0, q255});
  assign q255_fix = q255 + {15'b0, (rem255 >= 25'd255)};

  assign d_sel = sel_two_r ? d_two_r : d_one_r;

  // Operand select for the shared multiplier
  always_comb begin
    case (state_r)
      ST_EVAL: begin
        mul_a = {17'b0, mix_a};
        mul_b = {9'b0, t_base};
      end
      ST_MIX_RCP: begin
        mul_a = {9'b0, prod_r[14:0]};
        mul_b = RCP127;
      end
      ST_SC_MUL: begin
        mul_a = {8'b0, pwm_max_r};
        mul_b = {9'b0, d_sel};
      end
      ST_SC_RCP: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = RCP255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    sel_two_nxt    = sel_two_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    dir_nxt        = dir_r;
    duty_one_nxt   = duty_one_r;
    duty_two_nxt   = duty_two_r;
    miss_nxt       = miss_r;
    status_nxt     = status_r;
    d_one_nxt      = d_one_r;
    d_two_nxt      = d_two_r;
    scaled_one_nxt = scaled_one_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (kind_r == KIND_POLL) begin
          // Count the miss (saturating); time out on the count held before
          if (miss_r != MISS_SAT) begin
            miss_nxt = miss_r + 16'd1;
          end
          if (miss_r > miss_limit_r) begin
            dir_nxt    = DIR_STOP;
            status_nxt = STAT_TIMEOUT;
          end else begin
            status_nxt = STAT_MISSED;
          end
          state_nxt = ST_EMIT;
        end else if (!chk_ok) begin
          // Drop the frame, hold everything
          status_nxt = STAT_CHK_ERR;
          state_nxt  = ST_EMIT;
        end else begin
          if (sw_r[SW_FWD_BIT]) begin
            dir_nxt = DIR_FORWARD;
          end else if (sw_r[SW_REV_BIT]) begin
            dir_nxt = DIR_REVERSE;
          end else begin
            dir_nxt = DIR_STOP;
          end
          miss_nxt   = '0;
          status_nxt = STAT_APPLIED;
          state_nxt  = ST_MIX_RCP;
        end
      end

      ST_MIX_RCP: begin
        state_nxt = ST_MIX_FIX;
      end

      ST_MIX_FIX: begin
        if (s_neg) begin
          d_one_nxt = t_base;
          d_two_nxt = q127_fix;
        end else begin
          d_one_nxt = t_base - q127_fix;
          d_two_nxt = t_base;
        end
        sel_two_nxt = 1'b0;
        state_nxt   = ST_SC_MUL;
      end

      ST_SC_MUL: begin
        state_nxt = ST_SC_RCP;
      end

      ST_SC_RCP: begin
        state_nxt = ST_SC_FIX;
      end

      ST_SC_FIX: begin
        if (!sel_two_r) begin
          scaled_one_nxt = q255_fix;
          sel_two_nxt    = 1'b1;
          state_nxt      = ST_SC_MUL;
        end else begin
          duty_one_nxt = scaled_one_r;
          duty_two_nxt = q255_fix;
          state_nxt    = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sel_two_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      dir_r        <= DIR_STOP;
      duty_one_r   <= '0;
      duty_two_r   <= '0;
      miss_r       <= '0;
      pwm_max_r    <= 16'd255;
      miss_limit_r <= 16'd100;
    end else begin
      state_r     <= state_nxt;
      sel_two_r   <= sel_two_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r       <= dir_nxt;
      duty_one_r  <= duty_one_nxt;
      duty_two_r  <= duty_two_nxt;
      miss_r      <= miss_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PWM_MAX:    pwm_max_r    <= cfg_wdata;
          CFG_MISS_LIMIT: miss_limit_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_kind;
      steer_r <= in_steering;
      thr_r   <= in_throttle;
      sw_r    <= in_switches;
      spare_r <= in_spare_channel;
      fsum_r  <= in_frame_sum;
    end
    status_r     <= status_nxt;
    d_one_r      <= d_one_nxt;
    d_two_r      <= d_two_nxt;
    scaled_one_r <= scaled_one_nxt;
    prod_r       <= mul_a * mul_b;
    if (state_r == ST_MIX_RCP || state_r == ST_SC_RCP) begin
      x_r <= prod_r[MUL_A_W-1:0];
    end
    if (state_r == ST_EMIT && out_free) begin
      out_status_r   <= status_r;
      out_dir_r      <= dir_r;
      out_duty_one_r <= duty_one_r;
      out_duty_two_r <= duty_two_r;
    end
  end

endmodule

`default_nettype wire

// ----- verif/rcfdd_tb_pkg.sv -----
`default_nettype none

package rcfdd_tb_pkg;

  import rcfdd_pkg::*;

  localparam int MIX_SPAN     = 127;
  localparam int DUTY_DIV     = 255;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic              kind;
    logic signed [7:0] steering;
    logic signed [7:0] throttle;
    logic [7:0]        switches;
    logic [7:0]        spare;
    logic [7:0]        frame_sum;
  } rc_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  direction;
    logic [15:0] duty_one;
    logic [15:0] duty_two;
  } drive_result_t;

  // Tracks the held drive state and queues the result each word should give.
  class mixer_scoreboard;
    logic [15:0]   pwm_max;
    logic [15:0]   miss_limit;
    logic [15:0]   miss_count;
    logic [1:0]    direction;
    logic [15:0]   duty_one;
    logic [15:0]   duty_two;
    drive_result_t held_drive_q[$];
    int unsigned   errors;

    function new();
      pwm_max    = 16'd255;
      miss_limit = 16'd100;
      miss_count = '0;
      direction  = DIR_STOP;
      duty_one   = '0;
      duty_two   = '0;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == CFG_PWM_MAX) pwm_max = value;
      else if (idx == CFG_MISS_LIMIT) miss_limit = value;
    endfunction

    function int clamp_byte(logic signed [7:0] b);
      int v;
      v = b;
      if (v < -MIX_SPAN) v = -MIX_SPAN;
      return v;
    endfunction

    function logic [15:0] scale_duty(int d);
      longint p;
      p = longint'(d) * longint'(pwm_max);
      return 16'(p / DUTY_DIV);
    endfunction

    function void note_word(rc_word_t w);
      logic [7:0]    sum8;
      logic [15:0]   old_misses;
      int            s;
      int            t;
      int            d1;
      int            d2;
      drive_result_t r;
      if (w.kind == KIND_FRAME) begin
        sum8 = $unsigned(w.steering) + $unsigned(w.throttle) + w.switches + w.spare;
        if (~sum8 != w.frame_sum) begin
          r.status = STAT_CHK_ERR;
        end else begin
          if (w.switches[SW_FWD_BIT]) direction = DIR_FORWARD;
          else if (w.switches[SW_REV_BIT]) direction = DIR_REVERSE;
          else direction = DIR_STOP;
          s = clamp_byte(w.steering);
          t = clamp_byte(w.throttle);
          if (s < 0) begin
            d1 = t + MIX_SPAN;
            d2 = ((s + MIX_SPAN) * d1) / MIX_SPAN;
          end else begin
            d2 = t + MIX_SPAN;
            d1 = d2 - (s * d2) / MIX_SPAN;
          end
          duty_one   = scale_duty(d1);
          duty_two   = scale_duty(d2);
          miss_count = '0;
          r.status   = STAT_APPLIED;
        end
      end else begin
        old_misses = miss_count;
        if (miss_count != MISS_SAT) miss_count = miss_count + 16'd1;
        if (old_misses > miss_limit) begin
          direction = DIR_STOP;
          r.status  = STAT_TIMEOUT;
        end else begin
          r.status  = STAT_MISSED;
        end
      end
      r.direction = direction;
      r.duty_one  = duty_one;
      r.duty_two  = duty_two;
      held_drive_q.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (held_drive_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no word outstanding, expected none, actual %h",
                   $time, got);
        return;
      end
      want = held_drive_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("direction", want.direction, got.direction);
      compare_field("duty_one", want.duty_one, got.duty_one);
      compare_field("duty_two", want.duty_two, got.duty_two);
    endfunction

    function int pending();
      return held_drive_q.size();
    endfunction
  endclass

endpackage

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;

  import rcfdd_pkg::*;
  import rcfdd_tb_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned.
  // The slowest legal stretch is a good frame's mix plus a long random stall on
  // each side, well under this.
  localparam int QUIET_LIMIT  = 3000;
  // Quiet cycles after the last result before touching the registers.
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_WORDS  = 64;
  localparam int RAND_PHASES  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_FRAME;
  logic signed [7:0]     in_steering = '0;
  logic signed [7:0]     in_throttle = '0;
  logic [7:0]            in_switches = '0;
  logic [7:0]            in_spare_channel = '0;
  logic [7:0]            in_frame_sum = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [1:0]            out_direction;
  logic [15:0]           out_duty_one;
  logic [15:0]           out_duty_two;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [15:0]           cfg_wdata = '0;

  int unsigned           in_idle_pct = 0;
  int unsigned           out_stall_pct = 0;
  int unsigned           quiet_cycles = 0;
  mixer_scoreboard       sb;

  rc_frame_differential_drive DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_steering      (in_steering),
    .in_throttle      (in_throttle),
    .in_switches      (in_switches),
    .in_spare_channel (in_spare_channel),
    .in_frame_sum     (in_frame_sum),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_direction    (out_direction),
    .out_duty_one     (out_duty_one),
    .out_duty_two     (out_duty_two),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: decide readiness afresh on every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Sample both channels at the rising edge: note each accepted word with the
  // scoreboard, check each accepted result, and watch for a stalled block.
  always @(posedge clk) begin : channel_monitor
    rc_word_t      seen_word;
    drive_result_t seen_result;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen_word.kind      = in_kind;
        seen_word.steering  = in_steering;
        seen_word.throttle  = in_throttle;
        seen_word.switches  = in_switches;
        seen_word.spare     = in_spare_channel;
        seen_word.frame_sum = in_frame_sum;
        sb.note_word(seen_word);
      end
      if (out_valid && out_ready) begin
        seen_result.status    = out_status;
        seen_result.direction = out_direction;
        seen_result.duty_one  = out_duty_one;
        seen_result.duty_two  = out_duty_two;
        sb.check_result(seen_result);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Biased byte: hit the clamp point, the edges and zero often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h80;
      1:       return 8'h81;
      2:       return 8'h7f;
      3:       return 8'h00;
      4:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a frame whose checksum byte matches its four channel bytes.
  function automatic rc_word_t good_frame(logic [7:0] s, logic [7:0] t,
                                          logic [7:0] sw, logic [7:0] spare);
    rc_word_t w;
    w.kind      = KIND_FRAME;
    w.steering  = s;
    w.throttle  = t;
    w.switches  = sw;
    w.spare     = spare;
    w.frame_sum = ~(s + t + sw + spare);
    return w;
  endfunction

  function automatic rc_word_t bad_frame();
    rc_word_t w;
    w = good_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    w.frame_sum = w.frame_sum ^ 8'($urandom_range(1, 255));
    return w;
  endfunction

  // A poll carries junk in the channel fields; the block must ignore it.
  function automatic rc_word_t poll_word();
    rc_word_t w;
    w = good_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    w.kind = KIND_POLL;
    if ($urandom_range(0, 1) == 0) w.frame_sum = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Offer one word, idling first at the current rate; return at the falling
  // edge after it was taken, with valid still high.
  task automatic send_word(input rc_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= w.kind;
    in_steering      <= w.steering;
    in_throttle      <= w.throttle;
    in_switches      <= w.switches;
    in_spare_channel <= w.spare;
    in_frame_sum     <= w.frame_sum;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every result is back and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both registers, one per cycle; call only with the block drained.
  task automatic set_config(input logic [15:0] pwm, input logic [15:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PWM_MAX;
    cfg_wdata <= pwm;
    sb.set_register(CFG_PWM_MAX, pwm);
    @(negedge clk);
    cfg_index <= CFG_MISS_LIMIT;
    cfg_wdata <= limit;
    sb.set_register(CFG_MISS_LIMIT, limit);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 83; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 83; end
      default: begin in_idle_pct = 25; out_stall_pct = 25; end
    endcase
  endtask

  initial begin : stimulus
    int          sent;
    int          burst;
    int unsigned pick;
    logic [15:0] pwm;
    logic [15:0] limit;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset settings (pwm_max 255, limit 100).
    send_word(poll_word());
    send_word(good_frame(8'h00, 8'h00, 8'(1 << SW_FWD_BIT), 8'h00));
    // Both channels at -128 clamp to -127; reverse only.
    send_word(good_frame(8'h80, 8'h80, 8'(1 << SW_REV_BIT), 8'h5a));
    // Both switch bits: forward must win.
    send_word(good_frame(8'h7f, 8'h7f, 8'h03, 8'hff));
    // No direction bit: stop, but the duties still move.
    send_word(good_frame(8'h81, 8'h7f, 8'h00, 8'h01));
    send_word(good_frame(8'h7f, 8'h80, 8'hfc, 8'h80));
    // Corrupt checksum: everything held.
    send_word(bad_frame());
    send_word(good_frame(8'hff, 8'h40, 8'(1 << SW_REV_BIT), 8'hff));
    send_word(good_frame(8'h01, 8'hff, 8'h01, 8'h80));
    send_word(poll_word());
    drain();

    // Full-scale duty and a zero miss limit: the second poll times out.
    set_config(16'hffff, 16'd0);
    send_word(good_frame(8'hc0, 8'h64, 8'h01, 8'h33));
    send_word(poll_word());
    send_word(poll_word());
    send_word(bad_frame());
    send_word(good_frame(8'h7f, 8'h7f, 8'h02, 8'h00));
    send_word(good_frame(8'h80, 8'h7f, 8'h01, 8'h00));
    drain();

    // Smallest scale: every duty truncates to zero.
    set_config(16'd1, 16'd2);
    send_word(good_frame(8'h00, 8'h7f, 8'h01, 8'h00));
    send_word(good_frame(8'h80, 8'h7f, 8'h02, 8'h10));
    drain();
    set_config(16'd0, 16'd2);
    send_word(good_frame(8'h20, 8'h7f, 8'h01, 8'haa));
    send_word(poll_word());
    drain();

    // Top limit: a run of polls must not time out; then a lower limit
    // must time out on the count already held.
    set_config(16'd255, 16'hffff);
    set_idling(0);
    repeat (6) send_word(poll_word());
    drain();
    set_config(16'd255, 16'd4);
    send_word(poll_word());
    send_word(poll_word());
    drain();

    // Random phases: mostly valid frames, bursts of polls to reach the limit,
    // some corrupt frames; settings and idling change between phases.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       begin pwm = 16'hffff;                limit = 16'd0;    end
        1:       begin pwm = 16'd1;                   limit = 16'hffff; end
        2:       begin pwm = 16'd255;                 limit = 16'd3;    end
        3:       begin pwm = 16'd0;                   limit = 16'd1;    end
        4:       begin pwm = 16'($urandom_range(1, 65535));
                       limit = 16'($urandom_range(0, 8));             end
        5:       begin pwm = 16'h8000;                limit = 16'd100;  end
        6:       begin pwm = 16'($urandom_range(1, 65535));
                       limit = 16'($urandom_range(0, 65535));         end
        default: begin pwm = 16'h7fff;                limit = 16'd5;    end
      endcase
      set_config(pwm, limit);
      set_idling(phase % 4);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          burst = $urandom_range(1, 10);
          repeat (burst) send_word(poll_word());
          sent += burst;
        end else if (pick < 30) begin
          send_word(bad_frame());
          sent++;
        end else begin
          send_word(good_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte()));
          sent++;
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
